FILE: rtl/cik_pkg.sv
// Shared types, constants and codes of the chassis inverse kinematics unit.
`timescale 1ns / 1ps
`default_nettype none
package cik_pkg;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   localparam int LANES = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int NORM_W = 16;
   localparam int SPEED_W = 31;
   localparam int COEFF_W = 32;
   localparam int WHEEL_W = 32;

   localparam logic [SPEED_W-1:0] INV_SQRT2_Q31 = 31'd1518500250;
   localparam logic [SPEED_W-1:0] UNIT_Q16 = 31'd65536;

   typedef enum logic [1:0] {
      OP_DISABLE,
      OP_HEADLESS,
      OP_ENABLE,
      OP_UNKNOWN
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DRIVEN,
      STATUS_STOPPED,
      STATUS_IGNORED
   } status_type;

   typedef enum logic [1:0] {
      CHASSIS_MECANUM_X,
      CHASSIS_MECANUM_O,
      CHASSIS_OMNI_X,
      CHASSIS_OMNI_CROSS
   } chassis_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_CHASSIS_TYPE,
      REG_TOP_SPEED,
      REG_TOP_TURN_RATE,
      REG_INV_RADIUS,
      REG_ROT_COEFF,
      REG_CROSS_A_COEFF,
      REG_CROSS_B_COEFF
   } reg_index_type;

   typedef struct packed {
      chassis_kind_type           chassis;
      logic [SPEED_W-1:0]         top_speed;
      logic [SPEED_W-1:0]         top_turn_rate;
      logic [SPEED_W-1:0]         inv_radius;
      logic signed [COEFF_W-1:0]  rot_coeff;
      logic signed [COEFF_W-1:0]  cross_a_coeff;
      logic signed [COEFF_W-1:0]  cross_b_coeff;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      chassis:       CHASSIS_MECANUM_X,
      top_speed:     UNIT_Q16,
      top_turn_rate: UNIT_Q16,
      inv_radius:    UNIT_Q16,
      rot_coeff:     32'sd65536,
      cross_a_coeff: 32'sd65536,
      cross_b_coeff: 32'sd65536
   };

   typedef struct packed {
      status_type                status;
      logic signed [NORM_W-1:0]  norm_vx;
      logic signed [NORM_W-1:0]  norm_vy;
      logic signed [NORM_W-1:0]  norm_w;
   } cmd_type;

   typedef struct packed {
      logic        valid;
      status_type  status;
   } ctl_type;

   typedef struct packed {
      logic signed [WHEEL_W-1:0]  wheel_lf;
      logic signed [WHEEL_W-1:0]  wheel_lb;
      logic signed [WHEEL_W-1:0]  wheel_rb;
      logic signed [WHEEL_W-1:0]  wheel_rf;
      status_type                 status;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/cik_fifo.sv
// Small flip-flop queue with first-word fall-through read, for depths of two and more.
`timescale 1ns / 1ps
`default_nettype none
module cik_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/cik_front.sv
// Command front end: accepts velocity commands, classifies the operation and queues them.
`timescale 1ns / 1ps
`default_nettype none
module cik_front #(
   parameter int CMD_DEPTH = cik_pkg::CMD_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic [1:0]                       req_operation,
   input  wire logic signed [cik_pkg::NORM_W-1:0] req_norm_vx,
   input  wire logic signed [cik_pkg::NORM_W-1:0] req_norm_vy,
   input  wire logic signed [cik_pkg::NORM_W-1:0] req_norm_w,
   input  wire logic                             cmd_pop,
   output cik_pkg::cmd_type                      cmd,
   output logic                                  cmd_empty
);

   cik_pkg::cmd_type cmd_wr;

   always_comb begin
      cmd_wr.norm_vx = req_norm_vx;
      cmd_wr.norm_vy = req_norm_vy;
      cmd_wr.norm_w  = req_norm_w;
      unique case (cik_pkg::op_type'(req_operation))
         cik_pkg::OP_ENABLE: begin
            cmd_wr.status = cik_pkg::STATUS_DRIVEN;
         end
         cik_pkg::OP_DISABLE, cik_pkg::OP_HEADLESS: begin
            cmd_wr.status = cik_pkg::STATUS_STOPPED;
         end
         cik_pkg::OP_UNKNOWN: begin
            cmd_wr.status = cik_pkg::STATUS_IGNORED;
         end
         default: begin
            cmd_wr.status = cik_pkg::STATUS_IGNORED;
         end
      endcase
   end

   cik_fifo #(
      .WIDTH ($bits(cik_pkg::cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (cmd_wr),
      .full    (req_full),
      .pop     (cmd_pop),
      .rd_data (cmd),
      .empty   (cmd_empty)
   );

endmodule
`default_nettype wire

FILE: rtl/cik_back.sv
// Arithmetic back end: scaling, wheel mixing, omni scaling, radius scaling and saturation.
`timescale 1ns / 1ps
`default_nettype none
module cik_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cik_pkg::cfg_type cfg,
   input  wire cik_pkg::cmd_type cmd,
   input  wire logic             cmd_empty,
   output logic                  cmd_pop,
   output cik_pkg::rsp_type      rsp,
   output logic                  rsp_push,
   input  wire logic             rsp_full
);

   localparam int NSTAGE  = 11;
   localparam int LANES   = cik_pkg::LANES;
   localparam int NORM_W  = cik_pkg::NORM_W;
   localparam int SPEED_W = cik_pkg::SPEED_W;
   localparam int COEFF_W = cik_pkg::COEFF_W;
   localparam int WHEEL_W = cik_pkg::WHEEL_W;
   localparam int PN_W    = NORM_W + SPEED_W;
   localparam int VEL_W   = SPEED_W + 1;
   localparam int PK_W    = SPEED_W + COEFF_W;
   localparam int MAG_W   = PK_W - 16;
   localparam int SUM_W   = MAG_W + 1;
   localparam int LO_W    = (MAG_W + 1) / 2;
   localparam int HI_W    = MAG_W - LO_W;
   localparam int PLO_W   = LO_W + SPEED_W;
   localparam int PHI_W   = HI_W + SPEED_W;
   localparam int PROD_W  = MAG_W + SPEED_W;
   localparam int RMAG_W  = PROD_W - 16;

   localparam int LANE_LF = 0;
   localparam int LANE_LB = 1;
   localparam int LANE_RB = 2;
   localparam int LANE_RF = 3;

   localparam logic signed [WHEEL_W-1:0] WHEEL_MAX = {1'b0, {(WHEEL_W-1){1'b1}}};
   localparam logic signed [WHEEL_W-1:0] WHEEL_MIN = {1'b1, {(WHEEL_W-1){1'b0}}};

   cik_pkg::ctl_type ctl_ff [NSTAGE];
   logic adv;

   logic [PN_W-1:0] s1_pvx_ff, s1_pvy_ff, s1_pw_ff, s1_pvx_in, s1_pvy_in, s1_pw_in;
   logic            s1_nx_ff, s1_ny_ff, s1_nw_ff;
   logic [NORM_W-1:0] mag_vx, mag_vy, mag_w;

   logic signed [VEL_W-1:0] s2_vx_ff, s2_vy_ff, s2_vx_in, s2_vy_in;
   logic [SPEED_W-1:0]      s2_wmag_ff, s2_wmag_in;
   logic                    s2_wneg_ff;
   logic [PN_W-1:0]         rnd_vx, rnd_vy, rnd_w;

   logic signed [VEL_W-1:0] s3_vx_ff, s3_vy_ff;
   logic [PK_W-1:0]         s3_pk_ff, s3_pb_ff, s3_pk_in, s3_pb_in;
   logic                    s3_nk_ff, s3_nb_ff, s3_nk_in, s3_nb_in;
   logic signed [COEFF_W-1:0] coef_k;
   logic [COEFF_W-1:0]      abs_k, abs_b;

   logic signed [VEL_W-1:0] s4_vx_ff, s4_vy_ff;
   logic signed [SUM_W-1:0] s4_wk_ff, s4_wb_ff, s4_wk_in, s4_wb_in;
   logic [PK_W-1:0]         rnd_k, rnd_b;

   logic signed [SUM_W-1:0] s5_sum_ff [LANES];
   logic signed [SUM_W-1:0] s5_sum_in [LANES];
   logic signed [SUM_W-1:0] ext_vx, ext_vy;

   logic [MAG_W-1:0]        s6_mag_ff [LANES];
   logic [MAG_W-1:0]        s6_mag_in [LANES];
   logic [LANES-1:0]        s6_neg_ff, s6_neg_in;
   logic [SUM_W-1:0]        abs_sum [LANES];

   logic [MAG_W-1:0]        s7_mag_ff [LANES];
   logic [PLO_W-1:0]        s7_plo_ff [LANES];
   logic [PLO_W-1:0]        s7_plo_in [LANES];
   logic [PHI_W-1:0]        s7_phi_ff [LANES];
   logic [PHI_W-1:0]        s7_phi_in [LANES];
   logic [LANES-1:0]        s7_neg_ff;

   logic [MAG_W-1:0]        s8_mag_ff [LANES];
   logic [MAG_W-1:0]        s8_mag_in [LANES];
   logic [LANES-1:0]        s8_neg_ff;
   logic [PROD_W-1:0]       omni_total [LANES];

   logic [PLO_W-1:0]        s9_plo_ff [LANES];
   logic [PLO_W-1:0]        s9_plo_in [LANES];
   logic [PHI_W-1:0]        s9_phi_ff [LANES];
   logic [PHI_W-1:0]        s9_phi_in [LANES];
   logic [LANES-1:0]        s9_neg_ff;

   logic [RMAG_W-1:0]       s10_mag_ff [LANES];
   logic [RMAG_W-1:0]       s10_mag_in [LANES];
   logic [LANES-1:0]        s10_neg_ff;
   logic [PROD_W-1:0]       rad_total [LANES];

   logic signed [WHEEL_W-1:0] s11_wheel_ff [LANES];
   logic signed [WHEEL_W-1:0] s11_wheel_in [LANES];
   logic pos_over, neg_over;

   assign adv      = !(ctl_ff[NSTAGE-1].valid && rsp_full);
   assign cmd_pop  = adv && !cmd_empty;
   assign rsp_push = ctl_ff[NSTAGE-1].valid && !rsp_full;

   always_comb begin
      mag_vx = cmd.norm_vx[NORM_W-1] ? (~cmd.norm_vx + 1'b1) : cmd.norm_vx;
      mag_vy = cmd.norm_vy[NORM_W-1] ? (~cmd.norm_vy + 1'b1) : cmd.norm_vy;
      mag_w  = cmd.norm_w[NORM_W-1] ? (~cmd.norm_w + 1'b1) : cmd.norm_w;
      s1_pvx_in = PN_W'(mag_vx) * PN_W'(cfg.top_speed);
      s1_pvy_in = PN_W'(mag_vy) * PN_W'(cfg.top_speed);
      s1_pw_in  = PN_W'(mag_w) * PN_W'(cfg.top_turn_rate);

      rnd_vx = s1_pvx_ff + (PN_W'(1) << 14);
      rnd_vy = s1_pvy_ff + (PN_W'(1) << 14);
      rnd_w  = s1_pw_ff + (PN_W'(1) << 14);
      s2_vx_in = s1_nx_ff ? ~{1'b0, rnd_vx[PN_W-2:15]} + 1'b1 : {1'b0, rnd_vx[PN_W-2:15]};
      s2_vy_in = s1_ny_ff ? ~{1'b0, rnd_vy[PN_W-2:15]} + 1'b1 : {1'b0, rnd_vy[PN_W-2:15]};
      s2_wmag_in = rnd_w[PN_W-2:15];

      coef_k = (cfg.chassis == cik_pkg::CHASSIS_OMNI_CROSS) ? cfg.cross_a_coeff
                                                           : cfg.rot_coeff;
      abs_k = coef_k[COEFF_W-1] ? (~coef_k + 1'b1) : coef_k;
      abs_b = cfg.cross_b_coeff[COEFF_W-1] ? (~cfg.cross_b_coeff + 1'b1)
                                           : cfg.cross_b_coeff;
      s3_pk_in = PK_W'(s2_wmag_ff) * PK_W'(abs_k);
      s3_pb_in = PK_W'(s2_wmag_ff) * PK_W'(abs_b);
      s3_nk_in = s2_wneg_ff ^ coef_k[COEFF_W-1];
      s3_nb_in = s2_wneg_ff ^ cfg.cross_b_coeff[COEFF_W-1];

      rnd_k = s3_pk_ff + (PK_W'(1) << 15);
      rnd_b = s3_pb_ff + (PK_W'(1) << 15);
      s4_wk_in = s3_nk_ff ? ~{1'b0, rnd_k[PK_W-1:16]} + 1'b1 : {1'b0, rnd_k[PK_W-1:16]};
      s4_wb_in = s3_nb_ff ? ~{1'b0, rnd_b[PK_W-1:16]} + 1'b1 : {1'b0, rnd_b[PK_W-1:16]};

      ext_vx = SUM_W'(s4_vx_ff);
      ext_vy = SUM_W'(s4_vy_ff);
      unique case (cfg.chassis)
         cik_pkg::CHASSIS_OMNI_CROSS: begin
            s5_sum_in[LANE_LF] = ext_vy + s4_wk_ff;
            s5_sum_in[LANE_LB] = s4_wb_ff - ext_vx;
            s5_sum_in[LANE_RB] = ext_vx + s4_wb_ff;
            s5_sum_in[LANE_RF] = s4_wk_ff - ext_vy;
         end
         cik_pkg::CHASSIS_MECANUM_O: begin
            s5_sum_in[LANE_LF] = ext_vx + ext_vy - s4_wk_ff;
            s5_sum_in[LANE_LB] = ext_vx - ext_vy - s4_wk_ff;
            s5_sum_in[LANE_RB] = ext_vx + ext_vy + s4_wk_ff;
            s5_sum_in[LANE_RF] = ext_vx - ext_vy + s4_wk_ff;
         end
         default: begin
            s5_sum_in[LANE_LF] = ext_vx - ext_vy - s4_wk_ff;
            s5_sum_in[LANE_LB] = ext_vx + ext_vy - s4_wk_ff;
            s5_sum_in[LANE_RB] = ext_vx - ext_vy + s4_wk_ff;
            s5_sum_in[LANE_RF] = ext_vx + ext_vy + s4_wk_ff;
         end
      endcase

      for (int l = 0; l < LANES; l++) begin
         abs_sum[l] = s5_sum_ff[l][SUM_W-1] ? (~s5_sum_ff[l] + 1'b1) : s5_sum_ff[l];
         s6_mag_in[l] = abs_sum[l][MAG_W-1:0];
         s6_neg_in[l] = s5_sum_ff[l][SUM_W-1];

         s7_plo_in[l] = PLO_W'(s6_mag_ff[l][LO_W-1:0]) * PLO_W'(cik_pkg::INV_SQRT2_Q31);
         s7_phi_in[l] = PHI_W'(s6_mag_ff[l][MAG_W-1:LO_W]) * PHI_W'(cik_pkg::INV_SQRT2_Q31);

         omni_total[l] = (PROD_W'(s7_phi_ff[l]) << LO_W) + PROD_W'(s7_plo_ff[l])
                         + (PROD_W'(1) << 30);
         s8_mag_in[l] = (cfg.chassis == cik_pkg::CHASSIS_OMNI_X)
                        ? omni_total[l][PROD_W-1:31] : s7_mag_ff[l];

         s9_plo_in[l] = PLO_W'(s8_mag_ff[l][LO_W-1:0]) * PLO_W'(cfg.inv_radius);
         s9_phi_in[l] = PHI_W'(s8_mag_ff[l][MAG_W-1:LO_W]) * PHI_W'(cfg.inv_radius);

         rad_total[l] = (PROD_W'(s9_phi_ff[l]) << LO_W) + PROD_W'(s9_plo_ff[l])
                        + (PROD_W'(1) << 15);
         s10_mag_in[l] = rad_total[l][PROD_W-1:16];
      end

      for (int l = 0; l < LANES; l++) begin
         pos_over = |s10_mag_ff[l][RMAG_W-1:WHEEL_W-1];
         neg_over = (|s10_mag_ff[l][RMAG_W-1:WHEEL_W])
                    || (s10_mag_ff[l][WHEEL_W-1] && (|s10_mag_ff[l][WHEEL_W-2:0]));
         if (ctl_ff[NSTAGE-2].status != cik_pkg::STATUS_DRIVEN) begin
            s11_wheel_in[l] = '0;
         end else if (s10_neg_ff[l]) begin
            s11_wheel_in[l] = neg_over ? WHEEL_MIN
                                       : ~s10_mag_ff[l][WHEEL_W-1:0] + 1'b1;
         end else begin
            s11_wheel_in[l] = pos_over ? WHEEL_MAX
                                       : {1'b0, s10_mag_ff[l][WHEEL_W-2:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTAGE; i++) begin
            ctl_ff[i].valid  <= 1'b0;
            ctl_ff[i].status <= cik_pkg::STATUS_STOPPED;
         end
      end else if (adv) begin
         ctl_ff[0].valid  <= !cmd_empty;
         ctl_ff[0].status <= cmd.status;
         for (int i = 1; i < NSTAGE; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pvx_ff <= s1_pvx_in;
         s1_pvy_ff <= s1_pvy_in;
         s1_pw_ff  <= s1_pw_in;
         s1_nx_ff  <= cmd.norm_vx[NORM_W-1];
         s1_ny_ff  <= cmd.norm_vy[NORM_W-1];
         s1_nw_ff  <= cmd.norm_w[NORM_W-1];

         s2_vx_ff   <= s2_vx_in;
         s2_vy_ff   <= s2_vy_in;
         s2_wmag_ff <= s2_wmag_in;
         s2_wneg_ff <= s1_nw_ff;

         s3_vx_ff <= s2_vx_ff;
         s3_vy_ff <= s2_vy_ff;
         s3_pk_ff <= s3_pk_in;
         s3_pb_ff <= s3_pb_in;
         s3_nk_ff <= s3_nk_in;
         s3_nb_ff <= s3_nb_in;

         s4_vx_ff <= s3_vx_ff;
         s4_vy_ff <= s3_vy_ff;
         s4_wk_ff <= s4_wk_in;
         s4_wb_ff <= s4_wb_in;

         s6_neg_ff  <= s6_neg_in;
         s7_neg_ff  <= s6_neg_ff;
         s8_neg_ff  <= s7_neg_ff;
         s9_neg_ff  <= s8_neg_ff;
         s10_neg_ff <= s9_neg_ff;

         for (int l = 0; l < LANES; l++) begin
            s5_sum_ff[l]    <= s5_sum_in[l];
            s6_mag_ff[l]    <= s6_mag_in[l];
            s7_mag_ff[l]    <= s6_mag_ff[l];
            s7_plo_ff[l]    <= s7_plo_in[l];
            s7_phi_ff[l]    <= s7_phi_in[l];
            s8_mag_ff[l]    <= s8_mag_in[l];
            s9_plo_ff[l]    <= s9_plo_in[l];
            s9_phi_ff[l]    <= s9_phi_in[l];
            s10_mag_ff[l]   <= s10_mag_in[l];
            s11_wheel_ff[l] <= s11_wheel_in[l];
         end
      end
   end

   always_comb begin
      rsp.wheel_lf = s11_wheel_ff[LANE_LF];
      rsp.wheel_lb = s11_wheel_ff[LANE_LB];
      rsp.wheel_rb = s11_wheel_ff[LANE_RB];
      rsp.wheel_rf = s11_wheel_ff[LANE_RF];
      rsp.status   = ctl_ff[NSTAGE-1].status;
   end

endmodule
`default_nettype wire

FILE: rtl/chassis_inverse_kinematics_unit.sv
// Top level of the chassis inverse kinematics unit: registers, command path and result queue.
`timescale 1ns / 1ps
`default_nettype none
// Each command transaction on the req_ side carries an operation and normalized vx, vy and w
// in Q1.15; exactly one result transaction with four wheel speeds in Q16.16 and a status comes
// back on the rsp_ side, in order. The unit takes one transaction per clock cycle as long as
// results are drained; each command passes a short command queue and then the eleven-stage
// arithmetic pipeline, whose multipliers are each used once per command. Configuration
// registers are written through the csr_ port, which is always ready, and must only be
// written while no command is in flight.
module chassis_inverse_kinematics_unit #(
   parameter int CMD_DEPTH = cik_pkg::CMD_DEPTH,
   parameter int RSP_DEPTH = cik_pkg::RSP_DEPTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_push,
   output logic                                        req_full,
   input  wire logic [1:0]                             req_operation,
   input  wire logic signed [cik_pkg::NORM_W-1:0]      req_norm_vx,
   input  wire logic signed [cik_pkg::NORM_W-1:0]      req_norm_vy,
   input  wire logic signed [cik_pkg::NORM_W-1:0]      req_norm_w,
   output logic                                        rsp_empty,
   input  wire logic                                   rsp_pop,
   output logic signed [cik_pkg::WHEEL_W-1:0]          rsp_wheel_lf,
   output logic signed [cik_pkg::WHEEL_W-1:0]          rsp_wheel_lb,
   output logic signed [cik_pkg::WHEEL_W-1:0]          rsp_wheel_rb,
   output logic signed [cik_pkg::WHEEL_W-1:0]          rsp_wheel_rf,
   output logic [1:0]                                  rsp_status,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [cik_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  wire logic [cik_pkg::CSR_DATA_W-1:0]         csr_data
);

   cik_pkg::cfg_type cfg_ff, cfg_in;
   cik_pkg::cmd_type cmd;
   cik_pkg::rsp_type rsp_wr;
   cik_pkg::rsp_type rsp_rd;
   logic             cmd_empty;
   logic             cmd_pop;
   logic             rsp_push;
   logic             rsp_full;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (cik_pkg::reg_index_type'(csr_index))
            cik_pkg::REG_CHASSIS_TYPE: begin
               cfg_in.chassis = cik_pkg::chassis_kind_type'(csr_data[1:0]);
            end
            cik_pkg::REG_TOP_SPEED: begin
               cfg_in.top_speed = csr_data[cik_pkg::SPEED_W-1:0];
            end
            cik_pkg::REG_TOP_TURN_RATE: begin
               cfg_in.top_turn_rate = csr_data[cik_pkg::SPEED_W-1:0];
            end
            cik_pkg::REG_INV_RADIUS: begin
               cfg_in.inv_radius = csr_data[cik_pkg::SPEED_W-1:0];
            end
            cik_pkg::REG_ROT_COEFF: begin
               cfg_in.rot_coeff = csr_data;
            end
            cik_pkg::REG_CROSS_A_COEFF: begin
               cfg_in.cross_a_coeff = csr_data;
            end
            cik_pkg::REG_CROSS_B_COEFF: begin
               cfg_in.cross_b_coeff = csr_data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cik_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cik_front #(
      .CMD_DEPTH (CMD_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_norm_vx   (req_norm_vx),
      .req_norm_vy   (req_norm_vy),
      .req_norm_w    (req_norm_w),
      .cmd_pop       (cmd_pop),
      .cmd           (cmd),
      .cmd_empty     (cmd_empty)
   );

   cik_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp       (rsp_wr),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   cik_fifo #(
      .WIDTH ($bits(cik_pkg::rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rd),
      .empty   (rsp_empty)
   );

   assign rsp_wheel_lf = rsp_rd.wheel_lf;
   assign rsp_wheel_lb = rsp_rd.wheel_lb;
   assign rsp_wheel_rb = rsp_rd.wheel_rb;
   assign rsp_wheel_rf = rsp_rd.wheel_rf;
   assign rsp_status   = rsp_rd.status;

endmodule
`default_nettype wire
